// ----- src/yee_curl_field_update_top_defines.svh -----
// Assertion macros for the Yee curl field update block.
// Used by yee_curl_field_update_top; expects clk and rst_n in scope.
`ifndef YEE_CURL_FIELD_UPDATE_TOP_DEFINES_SVH
`define YEE_CURL_FIELD_UPDATE_TOP_DEFINES_SVH

// Condition and consequence in the same cycle, checked out of reset
`define YCFU_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition now, consequence in the next cycle, checked out of reset
`define YCFU_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ycfu_pkg.sv -----
// Types and constants shared by the Yee curl field update block.
// No dependencies.
package ycfu_pkg;

  // Field and arithmetic widths
  localparam int FIELD_BITS = 32;
  localparam int SUM_W      = FIELD_BITS + 2;
  localparam int PROD_W     = FIELD_BITS + 19;
  localparam int COEF_W     = 16;
  localparam int DIMS_W     = 2;
  localparam int NREG_W     = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;
  localparam logic [NREG_W-1:0] NX_RESET   = 7'd64;
  localparam logic [NREG_W-1:0] NY_RESET   = 7'd64;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd14746;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DIMS = 2'd0,
    REG_NX   = 2'd1,
    REG_NY   = 2'd2,
    REG_COEF = 2'd3
  } cfg_reg_t;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  // Input beat
  typedef struct packed {
    logic   action;
    logic   first;
    logic   update;
    field_t dst_x;
    field_t dst_y;
    field_t dst_z;
    field_t src_x;
    field_t src_y;
    field_t src_z;
  } in_t;

  // Result beat
  typedef struct packed {
    field_t new_x;
    field_t new_y;
    field_t new_z;
    logic   clipped;
  } out_t;

endpackage

// ----- src/yee_curl_field_update_top.sv -----
// Yee curl field update: neighbour buffers, curl sums, scaling and saturation.
// Depends on ycfu_pkg and yee_curl_field_update_top_defines.svh.
//
//   port group | dir | handshake          | payload
//   in_*       | in  | in_valid/in_ready  | in_data  (ycfu_pkg::in_t)
//   out_*      | out | out_valid/out_ready| out_data (ycfu_pkg::out_t)
//   cfg_*      | in  | cfg_we             | cfg_addr, cfg_wdata
//
// One cell per cycle unless out_ready stalls; each stage and the output register hold the result in turn.
// The rate is set by the single read/write port of each neighbour buffer,
// which reads the neighbour and stores the cell's source in the accept cycle.
// Reset is synchronous; buffers hold no reset and need no clearing pass.
// A stall on out_ready backs up stage by stage; in_ready drops only once
// every stage holds a result. Halo cells update buffers and then drop.
module yee_curl_field_update_top
  import ycfu_pkg::*;
#(
  parameter int MAX_NX = 64,
  parameter int MAX_NY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FW     = FIELD_BITS;
  localparam int CW     = $clog2(MAX_NX);
  localparam int RW     = $clog2(MAX_NY);
  localparam int MW     = (CW > RW) ? CW : RW;
  localparam int EW     = ((MW > NREG_W) ? MW : NREG_W) + 1;
  localparam int PDEPTH = 1 << (CW + RW);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] RND_FULL = PROD_W'(16384);
  localparam logic [FW-1:0] FMAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] FMIN = {1'b1, {(FW-1){1'b0}}};

  // Configuration registers
  logic [DIMS_W-1:0] dims_r;
  logic [NREG_W-1:0] nx_r, ny_r;
  logic [COEF_W-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
      nx_r   <= NX_RESET;
      ny_r   <= NY_RESET;
      coef_r <= COEF_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DIMS: dims_r <= cfg_wdata[DIMS_W-1:0];
        REG_NX:   nx_r   <= cfg_wdata[NREG_W-1:0];
        REG_NY:   ny_r   <= cfg_wdata[NREG_W-1:0];
        REG_COEF: coef_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and flow
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_free, s3_free, s2_free, s1_free, acc;

  assign out_free = !out_v_r || out_ready;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign acc      = in_valid && in_ready;

  // Effective row and plane extents
  logic [EW-1:0] nx_e, ny_e;

  always_comb begin
    if (nx_r == '0) begin
      nx_e = EW'(1);
    end else if (EW'(nx_r) > EW'(MAX_NX)) begin
      nx_e = EW'(MAX_NX);
    end else begin
      nx_e = EW'(nx_r);
    end
    if (ny_r == '0) begin
      ny_e = EW'(1);
    end else if (EW'(ny_r) > EW'(MAX_NY)) begin
      ny_e = EW'(MAX_NY);
    end else begin
      ny_e = EW'(ny_r);
    end
  end

  // Stream position; a first beat restarts at the origin
  logic [CW-1:0] col_r, col_cur, col_nxt;
  logic [RW-1:0] row_r, row_cur, row_nxt;

  assign col_cur = in_data.first ? '0 : col_r;
  assign row_cur = in_data.first ? '0 : row_r;

  always_comb begin
    if (EW'(col_cur) + EW'(1) >= nx_e) begin
      col_nxt = '0;
      row_nxt = (EW'(row_cur) + EW'(1) >= ny_e) ? '0 : row_cur + RW'(1);
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Neighbour buffers: read the upwind cell, then store this cell's source
  logic [2*FW-1:0] row_mem   [MAX_NX];
  logic [2*FW-1:0] plane_mem [PDEPTH];
  logic [2*FW-1:0] row_q_r, plane_q_r, prev_r, s1_prev_r;
  logic [CW+RW-1:0] paddr;

  assign paddr = {row_cur, col_cur};

  always_ff @(posedge clk) begin
    if (acc) begin
      row_q_r          <= row_mem[col_cur];
      row_mem[col_cur] <= {in_data.src_x, in_data.src_z};
      plane_q_r        <= plane_mem[paddr];
      plane_mem[paddr] <= {in_data.src_x, in_data.src_y};
      s1_prev_r        <= prev_r;
      prev_r           <= {in_data.src_y, in_data.src_z};
    end
  end

  // Stage 1: hold the beat next to its neighbour data
  field_t s1_dst_r [3];
  field_t s1_src_r [3];
  logic   s1_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= acc && in_data.update;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_half_r   <= in_data.action;
      s1_dst_r[0] <= in_data.dst_x;
      s1_dst_r[1] <= in_data.dst_y;
      s1_dst_r[2] <= in_data.dst_z;
      s1_src_r[0] <= in_data.src_x;
      s1_src_r[1] <= in_data.src_y;
      s1_src_r[2] <= in_data.src_z;
    end
  end

  // Curl sums: neighbour minus centre, disabled axes give zero
  field_t pv_y, pv_z, rw_x, rw_z, pl_x, pl_y;
  logic signed [SUM_W-1:0] di_y, di_z, dj_x, dj_z, dk_x, dk_y;
  logic signed [SUM_W-1:0] sum [3];
  logic use_j, use_k;

  assign pv_y  = s1_prev_r[2*FW-1:FW];
  assign pv_z  = s1_prev_r[FW-1:0];
  assign rw_x  = row_q_r[2*FW-1:FW];
  assign rw_z  = row_q_r[FW-1:0];
  assign pl_x  = plane_q_r[2*FW-1:FW];
  assign pl_y  = plane_q_r[FW-1:0];
  assign use_j = dims_r[1];
  assign use_k = (dims_r == DIMS_RESET);

  always_comb begin
    di_y = SUM_W'(pv_y) - SUM_W'(s1_src_r[1]);
    di_z = SUM_W'(pv_z) - SUM_W'(s1_src_r[2]);
    dj_x = use_j ? SUM_W'(rw_x) - SUM_W'(s1_src_r[0]) : '0;
    dj_z = use_j ? SUM_W'(rw_z) - SUM_W'(s1_src_r[2]) : '0;
    dk_x = use_k ? SUM_W'(pl_x) - SUM_W'(s1_src_r[0]) : '0;
    dk_y = use_k ? SUM_W'(pl_y) - SUM_W'(s1_src_r[1]) : '0;
    sum[0] = dk_y - dj_z;
    sum[1] = di_z - dk_x;
    sum[2] = dj_x - di_y;
  end

  // Stage 2: registered curl sums
  logic signed [SUM_W-1:0] s2_sum_r [3];
  field_t                  s2_dst_r [3];
  logic                    s2_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      s2_half_r <= s1_half_r;
      for (int i = 0; i < 3; i++) begin
        s2_sum_r[i] <= sum[i];
        s2_dst_r[i] <= s1_dst_r[i];
      end
    end
  end

  // Stage 3: registered products coef * sum
  logic signed [PROD_W-1:0] s3_prod_r [3];
  field_t                   s3_dst_r  [3];
  logic                     s3_half_r;
  logic signed [COEF_W:0]   coef_s;

  assign coef_s = {1'b0, coef_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_v_r) begin
      s3_half_r <= s2_half_r;
      for (int i = 0; i < 3; i++) begin
        s3_prod_r[i] <= PROD_W'(coef_s * s2_sum_r[i]);
        s3_dst_r[i]  <= s2_dst_r[i];
      end
    end
  end

  // Round half up, shift, add to destination and saturate
  logic signed [PROD_W-1:0] rnd  [3];
  logic signed [PROD_W-1:0] term [3];
  logic signed [PROD_W:0]   tot  [3];
  logic [PROD_W-FW+1:0]     top  [3];
  logic [FW-1:0]            res  [3];
  logic [2:0]               clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = s3_prod_r[i] + (s3_half_r ? RND_HALF : RND_FULL);
      term[i] = s3_half_r ? (rnd[i] >>> 16) : (rnd[i] >>> 15);
      tot[i]  = (PROD_W+1)'(term[i]) + (PROD_W+1)'(s3_dst_r[i]);
      top[i]  = tot[i][PROD_W:FW-1];
      clip[i] = !((&top[i]) || !(|top[i]));
      if (clip[i]) begin
        res[i] = tot[i][PROD_W] ? FMIN : FMAX;
      end else begin
        res[i] = tot[i][FW-1:0];
      end
    end
  end

  // Output register
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_v_r) begin
      out_data_r.new_x   <= res[0];
      out_data_r.new_y   <= res[1];
      out_data_r.new_z   <= res[2];
      out_data_r.clipped <= |clip;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // Checks
  logic on_rail;

  assign on_rail = (out_data_r.new_x == FMAX) || (out_data_r.new_x == FMIN) ||
                   (out_data_r.new_y == FMAX) || (out_data_r.new_y == FMIN) ||
                   (out_data_r.new_z == FMAX) || (out_data_r.new_z == FMIN);

  `include "yee_curl_field_update_top_defines.svh"

  `YCFU_IMPLIES_NEXT(a_halo_drop, acc && !in_data.update, !s1_v_r, "halo beat entered pipeline")
  `YCFU_IMPLIES_NEXT(a_cell_enter, acc && in_data.update, s1_v_r, "interior beat was lost")
  `YCFU_IMPLIES_NEXT(a_s2_hold, s2_v_r && !s3_free, s2_v_r && $stable(s2_sum_r[0]), "sum moved")
  `YCFU_IMPLIES_NEXT(a_out_fill, s3_v_r && out_free, out_v_r, "result did not reach output")
  `YCFU_IMPLIES(a_clip_rail, out_v_r && out_data_r.clipped, on_rail, "clip flag without rail value")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the Yee curl field update block: raster sweeps of
// halo and interior cells, with a scoreboard that predicts each field update.
// Depends on ycfu_pkg and yee_curl_field_update_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ycfu_pkg::*;

  localparam int GRID_NX = 64;
  localparam int GRID_NY = 64;
  localparam field_t F_MAX = 32'sh7FFF_FFFF;
  localparam field_t F_MIN = 32'sh8000_0000;

  // Tracks the neighbour buffers and stream position and predicts each update.
  class curl_update_scoreboard;
    out_t   expected_updates[$];
    int     mismatches;
    int     updates_checked;
    int     cells_noted;
    logic [DIMS_W-1:0] dims;
    logic [NREG_W-1:0] grid_nx;
    logic [NREG_W-1:0] grid_ny;
    logic [COEF_W-1:0] coef;
    field_t prev_y, prev_z;
    field_t row_x[GRID_NX];
    field_t row_z[GRID_NX];
    field_t plane_x[GRID_NX*GRID_NY];
    field_t plane_y[GRID_NX*GRID_NY];
    bit     prev_seen;
    bit     row_seen[GRID_NX];
    bit     plane_seen[GRID_NX*GRID_NY];
    int     col_pos, row_pos;

    function new();
      dims    = DIMS_RESET;
      grid_nx = NX_RESET;
      grid_ny = NY_RESET;
      coef    = COEF_RESET;
    endfunction

    function int axes();
      return (dims == 0) ? 1 : int'(dims);
    endfunction

    function int span(int n, int lim);
      return (n == 0) ? 1 : ((n > lim) ? lim : n);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_DIMS: dims = v[DIMS_W-1:0];
        REG_NX:   grid_nx = v[NREG_W-1:0];
        REG_NY:   grid_ny = v[NREG_W-1:0];
        REG_COEF: coef = v[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // Drop the update flag of a cell whose enabled neighbours were never stored.
    function in_t settle_update(in_t b);
      int col;
      int row;
      int pidx;
      col  = b.first ? 0 : col_pos;
      row  = b.first ? 0 : row_pos;
      pidx = row * GRID_NX + col;
      if (!prev_seen || (axes() >= 2 && !row_seen[col]) ||
          (axes() >= 3 && !plane_seen[pidx])) begin
        b.update = 1'b0;
      end
      return b;
    endfunction

    // Scale a curl sum by coef, round half up; the half step shifts one more.
    function longint curl_term(longint s, bit half);
      longint p;
      p = longint'(coef) * s;
      return half ? ((p + 32768) >>> 16) : ((p + 16384) >>> 15);
    endfunction

    function field_t clamp(longint v, inout bit clip);
      if (v > longint'(F_MAX)) begin
        clip = 1'b1;
        return F_MAX;
      end
      if (v < longint'(F_MIN)) begin
        clip = 1'b1;
        return F_MIN;
      end
      return field_t'(v);
    endfunction

    // Read neighbours, predict the update, then store the source and advance.
    function void note_cell(in_t b);
      int     col, row, pidx;
      longint sx, sy, sz;
      longint di_y, di_z;
      longint dj_x, dj_z, dk_x, dk_y;
      bit     clip;
      out_t   want;
      cells_noted++;
      if (b.first) begin
        col_pos = 0;
        row_pos = 0;
      end
      col  = col_pos;
      row  = row_pos;
      pidx = row * GRID_NX + col;
      sx = longint'(b.src_x);
      sy = longint'(b.src_y);
      sz = longint'(b.src_z);
      di_y = longint'(prev_y) - sy;
      di_z = longint'(prev_z) - sz;
      dj_x = 0;
      dj_z = 0;
      dk_x = 0;
      dk_y = 0;
      if (axes() >= 2) begin
        dj_x = longint'(row_x[col]) - sx;
        dj_z = longint'(row_z[col]) - sz;
      end
      if (axes() >= 3) begin
        dk_x = longint'(plane_x[pidx]) - sx;
        dk_y = longint'(plane_y[pidx]) - sy;
      end
      if (b.update) begin
        clip = 1'b0;
        want.new_x = clamp(longint'(b.dst_x) + curl_term(dk_y - dj_z, b.action), clip);
        want.new_y = clamp(longint'(b.dst_y) + curl_term(di_z - dk_x, b.action), clip);
        want.new_z = clamp(longint'(b.dst_z) + curl_term(dj_x - di_y, b.action), clip);
        want.clipped = clip;
        expected_updates.push_back(want);
      end
      prev_y = b.src_y;
      prev_z = b.src_z;
      row_x[col] = b.src_x;
      row_z[col] = b.src_z;
      plane_x[pidx] = b.src_x;
      plane_y[pidx] = b.src_y;
      prev_seen = 1'b1;
      row_seen[col] = 1'b1;
      plane_seen[pidx] = 1'b1;
      if (col + 1 >= span(int'(grid_nx), GRID_NX)) begin
        col_pos = 0;
        row_pos = (row + 1 >= span(int'(grid_ny), GRID_NY)) ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
        row_pos = row;
      end
    endfunction

    function void check_update(out_t got);
      out_t want;
      updates_checked++;
      if (expected_updates.size() == 0) begin
        $error("result beat with no cell update pending");
        mismatches++;
        return;
      end
      want = expected_updates.pop_front();
      if (got.new_x !== want.new_x) begin
        $error("new_x: expected %0d, got %0d", want.new_x, got.new_x);
        mismatches++;
      end
      if (got.new_y !== want.new_y) begin
        $error("new_y: expected %0d, got %0d", want.new_y, got.new_y);
        mismatches++;
      end
      if (got.new_z !== want.new_z) begin
        $error("new_z: expected %0d, got %0d", want.new_z, got.new_z);
        mismatches++;
      end
      if (got.clipped !== want.clipped) begin
        $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit calm_in = 1'b0;
  curl_update_scoreboard sb = new();

  yee_curl_field_update_top #(
    .MAX_NX(GRID_NX),
    .MAX_NY(GRID_NY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mix extremes, full-range words and small values that stay unsaturated.
  function automatic field_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return F_MAX;
    if (r < 16) return F_MIN;
    if (r < 20) return '0;
    if (r < 55) return field_t'($urandom);
    return field_t'(int'($urandom_range(2097152)) - 1048576);
  endfunction

  function automatic in_t mk(bit act, bit fst, bit upd, field_t d, field_t s);
    in_t b;
    b.action = act;
    b.first  = fst;
    b.update = upd;
    b.dst_x  = d;
    b.dst_y  = d;
    b.dst_z  = d;
    b.src_x  = s;
    b.src_y  = ~s;
    b.src_z  = s;
    return b;
  endfunction

  // Offer one beat after random idle cycles; hold it until accepted.
  task automatic send_cell(in_t b);
    while (!calm_in && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_cell(b);
  endtask

  task automatic program_grid(int d, int gx, int gy, int c);
    cfg_reg_t idx[4];
    int       val[4];
    idx = '{REG_DIMS, REG_NX, REG_NY, REG_COEF};
    val = '{d, gx, gy, c};
    foreach (idx[i]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i][CFG_DATA_W-1:0];
      @(posedge clk);
      sb.write_reg(idx[i], val[i][CFG_DATA_W-1:0]);
    end
    cfg_we <= 1'b0;
  endtask

  // Wait until no update is pending or the wait times out, then let the input idle.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.expected_updates.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
  endtask

  // One raster sweep: halo on the low faces of enabled axes, random content.
  task automatic run_sweep(int snx, int sny, int snz, int ax, bit act);
    in_t b;
    for (int p = 0; p < snz; p++) begin
      for (int r = 0; r < sny; r++) begin
        for (int c = 0; c < snx; c++) begin
          b.action = act;
          b.first  = (p == 0 && r == 0 && c == 0);
          b.update = !((snx > 1 && c == 0) || (ax >= 2 && sny > 1 && r == 0) ||
                       (ax >= 3 && p == 0));
          b.dst_x = pick_value();
          b.dst_y = pick_value();
          b.dst_z = pick_value();
          b.src_x = pick_value();
          b.src_y = pick_value();
          b.src_z = pick_value();
          // break the sequence now and then
          if ($urandom_range(99) < 8) begin
            b.first  = 1'($urandom_range(1));
            b.update = 1'($urandom_range(1));
          end
          if ($urandom_range(99) < 2) b.action = ~act;
          send_cell(sb.settle_update(b));
        end
      end
    end
  endtask

  // Result side: random stalls, one long hold-off, one calm stretch.
  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_update(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && sb.cells_noted >= 600) begin
        held_once = 1'b1;
        hold_left = 150;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (sb.updates_checked >= 1000 && sb.updates_checked < 1150) ||
                     ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin
    int ph_dims[7];
    int ph_nx[7];
    int ph_ny[7];
    int ph_coef[7];
    int ph_nz[7];
    int ph_cells[7];
    int done;
    int snx, sny;
    bit act;
    ph_dims  = '{3, 2, 1, 3, 2, 0, 3};
    ph_nx    = '{4, 8, 1, 64, 2, 127, 5};
    ph_ny    = '{3, 5, 1, 2, 64, 0, 4};
    ph_coef  = '{65535, 0, 1, 14746, 40000, 3, 32768};
    ph_nz    = '{3, 1, 40, 2, 1, 2, 3};
    ph_cells = '{252, 160, 80, 512, 256, 128, 240};

    // Hold reset, then program a tiny grid for the directed cells
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_grid(3, 2, 2, 65535);

    // Fill the whole 2x2 plane with halo cells, then hit the extremes
    send_cell(sb.settle_update(mk(1'b0, 1'b1, 1'b0, 0, F_MAX)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b0, 0, F_MIN)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b0, 0, 0)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b0, 0, 32'sh5555_5555)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, 0, 0)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, F_MAX, F_MIN)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, F_MIN, F_MAX)));
    send_cell(sb.settle_update(mk(1'b1, 1'b0, 1'b1, F_MAX, F_MAX)));
    send_cell(sb.settle_update(mk(1'b1, 1'b0, 1'b1, F_MIN, F_MIN)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, 0, 32'shAAAA_AAAA)));
    send_cell(sb.settle_update(mk(1'b1, 1'b0, 1'b1, -1, 32'sh0001_0000)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, 1, -1)));
    send_cell(sb.settle_update(mk(1'b1, 1'b1, 1'b1, 32'sh0001_0000, 32'shFFFF_0000)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, F_MAX, 0)));
    send_cell(sb.settle_update(mk(1'b1, 1'b0, 1'b1, F_MIN, 0)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b0, F_MAX, F_MAX)));
    send_cell(sb.settle_update(mk(1'b0, 1'b0, 1'b1, 32'sh0000_8000, 32'sh0000_4000)));
    send_cell(sb.settle_update(mk(1'b1, 1'b0, 1'b1, 32'shFFFF_8000, 32'sh0000_0001)));

    // Random sweeps under each grid setting; E and B sweeps alternate
    act = 1'b0;
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      program_grid(ph_dims[ph], ph_nx[ph], ph_ny[ph], ph_coef[ph]);
      calm_in = (ph == 3);
      snx = sb.span(ph_nx[ph], GRID_NX);
      sny = sb.span(ph_ny[ph], GRID_NY);
      done = 0;
      while (done < ph_cells[ph]) begin
        run_sweep(snx, sny, ph_nz[ph], sb.axes(), act);
        act = ~act;
        done += snx * sny * ph_nz[ph];
      end
    end
    calm_in = 1'b0;

    drain();
    if (sb.expected_updates.size() != 0) begin
      $error("%0d cell updates never arrived", sb.expected_updates.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
